// File: sv/gmcp_pkg.sv
// gmcp_pkg: shared types, constants and the saturating adder for grid_min_cost_path.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package gmcp_pkg;

  typedef logic signed [31:0] cost_t;
  typedef logic signed [15:0] cell_cost_t;

  localparam cost_t COST_MAX = 32'sh7FFF_FFFF;
  localparam cost_t COST_MIN = 32'sh8000_0000;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_idx_t;

  // one result beat
  typedef struct packed {
    cost_t best_cost;
    logic  final_cell;
  } res_t;

  // output buffer status towards the top level
  typedef struct packed {
    logic full;
    logic out_valid;
  } buf_stat_t;

  // add a cell cost to a path cost, held to the signed 32-bit range
  function automatic cost_t sat_add(cost_t a, cell_cost_t b);
    logic [32:0] s;
    s = {a[31], a} + {{17{b[15]}}, b};
    if (s[32] != s[31]) begin
      return s[32] ? COST_MIN : COST_MAX;
    end
    return cost_t'(s[31:0]);
  endfunction

endpackage

// File: sv/gmcp_cell.sv
// gmcp_cell: one column slot of the row store chain.
// Uses gmcp_pkg for the cost type.
`timescale 1ns / 1ps

module gmcp_cell #(
  parameter int IDX_W = 10,
  parameter int POS   = 0
) (
  input  logic                 clk,
  input  logic                 shift_en,
  input  logic [IDX_W-1:0]     tail_idx,
  input  gmcp_pkg::cost_t      best_in,
  input  gmcp_pkg::cost_t      next_in,
  output gmcp_pkg::cost_t      val_out
);

  gmcp_pkg::cost_t val_r;
  gmcp_pkg::cost_t val_nxt;

  // the tail slot takes the fresh cost, the others take their neighbour
  always_comb begin
    val_nxt = (tail_idx == IDX_W'(POS)) ? best_in : next_in;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= val_nxt;
    end
  end

  assign val_out = val_r;

endmodule

// File: sv/gmcp_pe.sv
// gmcp_pe: position counters, left and diagonal costs, three-way minimum and add.
// Uses gmcp_pkg for types and the saturating adder.
`timescale 1ns / 1ps

module gmcp_pe #(
  parameter int CIDX_W = 10,
  parameter int RIDX_W = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  restart,
  input  gmcp_pkg::cell_cost_t  cell_cost,
  input  gmcp_pkg::cost_t       up_cost,
  input  logic [CIDX_W-1:0]     cols_last,
  input  logic [RIDX_W-1:0]     rows_last,
  output gmcp_pkg::res_t        res
);

  gmcp_pkg::cost_t     left_r, left_nxt;
  gmcp_pkg::cost_t     diag_r, diag_nxt;
  logic [CIDX_W-1:0]   col_r, col_nxt;
  logic [RIDX_W-1:0]   row_r, row_nxt;

  logic                have_left;
  logic                have_up;
  logic                last;
  gmcp_pkg::cost_t     m;
  gmcp_pkg::cost_t     best;

  always_comb begin
    have_left = (col_r != '0);
    have_up   = (row_r != '0);
    m = left_r;
    if (have_up) begin
      if (!have_left || (up_cost < m)) begin
        m = up_cost;
      end
      if (have_left && (diag_r < m)) begin
        m = diag_r;
      end
    end
    if (have_left || have_up) begin
      best = gmcp_pkg::sat_add(m, cell_cost);
    end else begin
      best = {{16{cell_cost[15]}}, cell_cost};
    end
    last = (row_r == rows_last) && (col_r == cols_last);
  end

  always_comb begin
    left_nxt = left_r;
    diag_nxt = diag_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      diag_nxt = up_cost;
      left_nxt = best;
      if (col_r == cols_last) begin
        col_nxt = '0;
        row_nxt = last ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      diag_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  assign res = '{best_cost: best, final_cell: last};

endmodule

// File: sv/gmcp_skid.sv
// gmcp_skid: two-entry output buffer that parts the input and result sides.
// Uses gmcp_pkg for the result and status types.
`timescale 1ns / 1ps

module gmcp_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gmcp_pkg::res_t       push_data,
  input  logic                 pop_ready,
  output gmcp_pkg::res_t       out_data,
  output gmcp_pkg::buf_stat_t  stat
);

  logic            out_v_r, out_v_nxt;
  logic            skid_v_r, skid_v_nxt;
  gmcp_pkg::res_t  out_d_r, out_d_nxt;
  gmcp_pkg::res_t  skid_d_r, skid_d_nxt;
  logic            pop;

  always_comb begin
    pop        = out_v_r && pop_ready;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop || !out_v_r) begin
      // output slot frees: refill from the skid first, else from the new beat
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      // output stalled: park the new beat
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_data = out_d_r;
  assign stat     = '{full: skid_v_r, out_valid: out_v_r};

endmodule

// File: sv/grid_min_cost_path.sv
// Result path: each result beat is registered in the output slot, or parked in the skid slot.
// Throughput: one beat per cycle while the skid slot is free, set by the loop from the
//   left-neighbour cost through the three-way minimum and saturating add.
// Reset (rst_n low, synchronous): position counters and left/diagonal costs clear, the grid
//   size returns to 1 x 1 and the output buffer empties; the row store is not cleared.
`timescale 1ns / 1ps

// Top level: config registers, row store chain of gmcp_cell, gmcp_pe, gmcp_skid.
// Depends on gmcp_pkg, gmcp_cell, gmcp_pe and gmcp_skid.

module grid_min_cost_path #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] cell_cost
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] best_cost
  output logic        out_tlast,   // final_cell
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CIDX_W = $clog2(MAX_COLS);
  localparam int RIDX_W = $clog2(MAX_ROWS);

  // Grid size is held as "last index" so the counters compare directly.
  logic [CIDX_W-1:0] cols_last_r, cols_last_nxt;
  logic [RIDX_W-1:0] rows_last_r, rows_last_nxt;
  logic              restart;
  logic [31:0]       cfg_v32;
  logic [31:0]       eff_cols;
  logic [31:0]       eff_rows;

  logic                 in_acc;
  gmcp_pkg::res_t       res;
  gmcp_pkg::res_t       out_data;
  gmcp_pkg::buf_stat_t  buf_stat;
  gmcp_pkg::cost_t      chain_val [MAX_COLS];

  // Clamp the written size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    cfg_v32  = 32'(cfg_data);
    eff_rows = (cfg_v32 == 32'd0) ? 32'd1 :
               (cfg_v32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_v32;
    eff_cols = (cfg_v32 == 32'd0) ? 32'd1 :
               (cfg_v32 > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cfg_v32;
  end

  always_comb begin
    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    restart       = 1'b0;
    if (cfg_wr_en) begin
      case (gmcp_pkg::reg_idx_t'(cfg_index))
        gmcp_pkg::REG_NUM_ROWS: begin
          rows_last_nxt = RIDX_W'(eff_rows - 32'd1);
          restart       = 1'b1;
        end
        gmcp_pkg::REG_NUM_COLS: begin
          cols_last_nxt = CIDX_W'(eff_cols - 32'd1);
          restart       = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= '0;
      cols_last_r <= '0;
    end else begin
      rows_last_r <= rows_last_nxt;
      cols_last_r <= cols_last_nxt;
    end
  end

  // Accept whenever the skid slot is free; the output slot may still hold a beat.
  assign in_tready = !buf_stat.full;
  assign in_acc    = in_tvalid && in_tready;

  // Row store as a shift chain: each accepted beat advances every slot one place towards
  // slot 0, and the fresh cost enters at slot cols_last. A cost written for column c thus
  // reaches slot 0 exactly one row later, when column c of the next row arrives.
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_row
    gmcp_pkg::cost_t next_val;
    if (k == MAX_COLS - 1) begin : g_tail
      assign next_val = res.best_cost;
    end else begin : g_body
      assign next_val = chain_val[k+1];
    end
    gmcp_cell #(
      .IDX_W (CIDX_W),
      .POS   (k)
    ) u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .tail_idx (cols_last_r),
      .best_in  (res.best_cost),
      .next_in  (next_val),
      .val_out  (chain_val[k])
    );
  end

  gmcp_pe #(
    .CIDX_W (CIDX_W),
    .RIDX_W (RIDX_W)
  ) u_pe (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .restart   (restart),
    .cell_cost (gmcp_pkg::cell_cost_t'(in_tdata)),
    .up_cost   (chain_val[0]),
    .cols_last (cols_last_r),
    .rows_last (rows_last_r),
    .res       (res)
  );

  gmcp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .pop_ready (out_tready),
    .out_data  (out_data),
    .stat      (buf_stat)
  );

  assign out_tvalid = buf_stat.out_valid;
  assign out_tdata  = out_data.best_cost;
  assign out_tlast  = out_data.final_cell;

`ifndef SYNTHESIS
  // A full skid implies the output slot is occupied.
  a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("skid holds a beat while the output slot is empty");

  // A beat accepted against a stalled output must fill the skid.
  a_stall_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tvalid && !out_tready) |=> !in_tready)
    else $error("beat accepted under stall did not land in the skid");

  // On a one-cell grid every result is the final cell.
  a_single_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (rows_last_r == '0) && (cols_last_r == '0)) |-> res.final_cell)
    else $error("one-cell grid result not flagged final");
`endif

endmodule

// File: tb/sv/path_cost_checker.sv
`timescale 1ns / 1ps
// path_cost_checker: watches the cell and result streams of grid_min_cost_path, predicts
// every path cost from its own copy of the grid state and compares beat by beat.
// Depends on gmcp_pkg for the cost types, the result struct and the register indexes.

module path_cost_checker #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] cell_cost
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,   // [31:0] best_cost
  input  logic        out_tlast,   // final_cell
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatches,
  output int          costs_due,
  output int          grids_done
);

  gmcp_pkg::cost_t prev_row [MAX_COLS];
  gmcp_pkg::cost_t left_cost = '0;
  gmcp_pkg::cost_t diag_cost = '0;
  int unsigned     row_pos = 0;
  int unsigned     col_pos = 0;
  logic [10:0]     rows_set = 11'd1;
  logic [10:0]     cols_set = 11'd1;
  gmcp_pkg::res_t  cost_due_q [$];
  int              n_bad = 0;
  int              n_grids = 0;

  // zero acts as one, anything past the store acts as the store size
  function automatic int unsigned span(logic [10:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic gmcp_pkg::cost_t clamp_sum(longint s);
    if (s > longint'(gmcp_pkg::COST_MAX)) return gmcp_pkg::COST_MAX;
    if (s < longint'(gmcp_pkg::COST_MIN)) return gmcp_pkg::COST_MIN;
    return gmcp_pkg::cost_t'(s);
  endfunction

  task automatic predict_path_cost(input gmcp_pkg::cell_cost_t cost);
    int unsigned     rows;
    int unsigned     cols;
    int unsigned     r;
    int unsigned     k;
    gmcp_pkg::cost_t up;
    gmcp_pkg::cost_t m;
    bit              have;
    gmcp_pkg::res_t  due;
    rows = span(rows_set, MAX_ROWS);
    cols = span(cols_set, MAX_COLS);
    k = (col_pos < cols) ? col_pos : cols - 1;
    r = (row_pos < rows) ? row_pos : rows - 1;
    up = prev_row[k];
    m = '0;
    have = 1'b0;
    if (k > 0) begin
      m = left_cost;
      have = 1'b1;
    end
    if (r > 0) begin
      if (!have || up < m) m = up;
      have = 1'b1;
      if (k > 0 && diag_cost < m) m = diag_cost;
    end
    due.best_cost  = have ? clamp_sum(longint'(cost) + longint'(m))
                          : gmcp_pkg::cost_t'(cost);
    due.final_cell = (r + 1 >= rows) && (k + 1 >= cols);
    diag_cost   = up;
    prev_row[k] = due.best_cost;
    left_cost   = due.best_cost;
    if (k + 1 >= cols) begin
      col_pos = 0;
      row_pos = due.final_cell ? 0 : r + 1;
    end else begin
      col_pos = k + 1;
      row_pos = r;
    end
    cost_due_q.insert(cost_due_q.size(), due);
  endtask

  always @(posedge clk) begin : watch
    gmcp_pkg::res_t head;
    if (!rst_n) begin
      left_cost = '0;
      diag_cost = '0;
      row_pos   = 0;
      col_pos   = 0;
      rows_set  = 11'd1;
      cols_set  = 11'd1;
      cost_due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (gmcp_pkg::reg_idx_t'(cfg_index))
          gmcp_pkg::REG_NUM_ROWS: rows_set = cfg_data;
          gmcp_pkg::REG_NUM_COLS: cols_set = cfg_data;
          default: ;
        endcase
        row_pos = 0;
        col_pos = 0;
      end
      // compare first so that a result can never match the cell taken at the same edge
      if (out_tvalid && out_tready) begin
        if (cost_due_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: best_cost %0d final_cell %0b",
                   $time, $signed(out_tdata), out_tlast);
          n_bad++;
        end else begin
          head = cost_due_q.pop_front();
          if (out_tdata !== head.best_cost) begin
            $display("%0t: best_cost mismatch: expected %0d, got %0d",
                     $time, head.best_cost, $signed(out_tdata));
            n_bad++;
          end
          if (out_tlast !== head.final_cell) begin
            $display("%0t: final_cell mismatch: expected %0b, got %0b",
                     $time, head.final_cell, out_tlast);
            n_bad++;
          end
          if (head.final_cell) n_grids++;
        end
      end
      if (in_tvalid && in_tready) predict_path_cost(gmcp_pkg::cell_cost_t'(in_tdata));
    end
    mismatches <= n_bad;
    costs_due  <= cost_due_q.size();
    grids_done <= n_grids;
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus, flow control and verdict for grid_min_cost_path.
// Depends on gmcp_pkg, the block itself and path_cost_checker.

module tb_top;

  // roughly this many random cell beats, split over the three idle mixes
  localparam int RAND_CELLS  = 45;
  // output hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 400;
  // no handshake for this long means a hang: the limit is set above the HOLD_CYCLES hold-off
  localparam int STALL_LIMIT = 4000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;    // [15:0] cell_cost
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] best_cost
  logic        out_tlast;          // final_cell
  logic        cfg_wr_en  = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [10:0] cfg_data   = '0;

  int mismatches;
  int costs_due;
  int grids_done;

  int in_idle_pct  = 14;
  int out_idle_pct = 66;
  bit hold_req     = 1'b0;
  int cells_sent   = 0;
  int n_settings   = 0;
  int quiet_cycles = 0;

  // corner costs for a 3 x 3 grid: both extremes on every kind of neighbour
  gmcp_pkg::cell_cost_t corner_costs [9] = '{16'sh7FFF, 16'sh8000, 16'sd1,
                                             16'sh8000, 16'sh7FFF, 16'sd0,
                                             16'sd5, -16'sd1, 16'sh7FFF};

  grid_min_cost_path #(
    .MAX_COLS(1024),
    .MAX_ROWS(1024)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  path_cost_checker #(
    .MAX_COLS(1024),
    .MAX_ROWS(1024)
  ) cost_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .costs_due (costs_due),
    .grids_done(grids_done)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, or a long hold-off on request. The hold-off is
  // counted here so the sender keeps offering beats while the block backs up.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Hang detector: any accepted beat on either side restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly arbitrary costs, with a fair share of both extremes and of small values
  // so that minima between neighbours are often close.
  function automatic gmcp_pkg::cell_cost_t rand_cost();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3, 4: return gmcp_pkg::cell_cost_t'($urandom_range(0, 400)) - 16'sd200;
      default: return gmcp_pkg::cell_cost_t'($urandom);
    endcase
  endfunction

  // Offer one cell beat, idling first at the sender's rate; return at the accepting edge.
  task automatic send_cell(input gmcp_pkg::cell_cost_t cost);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cost;
    do @(posedge clk); while (!in_tready);
    cells_sent++;
  endtask

  // Drop valid, hold until every expected result is back, then let the pipe settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (costs_due != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input gmcp_pkg::reg_idx_t idx, input logic [10:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [10:0] rows, input logic [10:0] cols);
    cfg_write(gmcp_pkg::REG_NUM_ROWS, rows);
    cfg_write(gmcp_pkg::REG_NUM_COLS, cols);
    n_settings++;
  endtask

  initial begin : stimulus
    int phase;
    int budget;
    int r;
    int c;
    int area;
    int n;
    bit keep;
    bit whole;

    area  = 1;
    whole = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reset size is 1 x 1: every beat is a whole grid
    send_cell(16'sh7FFF);
    send_cell(16'sh8000);
    drain_results();
    // zero in both registers still means a single cell
    set_grid(11'd0, 11'd0);
    send_cell(-16'sd1);
    drain_results();
    // 3 x 3 with extremes on left, upper and diagonal neighbours
    set_grid(11'd3, 11'd3);
    foreach (corner_costs[i]) send_cell(corner_costs[i]);
    drain_results();
    // start a 2 x 4 grid, then rewrite only the width: the grid restarts top-left
    set_grid(11'd2, 11'd4);
    repeat (3) send_cell(rand_cost());
    drain_results();
    cfg_write(gmcp_pkg::REG_NUM_COLS, 11'd2);
    n_settings++;
    repeat (4) send_cell(rand_cost());
    drain_results();
    // single column: only the upper neighbour exists below the top
    set_grid(11'd4, 11'd1);
    repeat (4) send_cell(rand_cost());

    // ---- random part, three idle mixes ----
    for (phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 14 : (phase == 1) ? 66 : 0;
      out_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 14 : 0;

      if (phase == 0) begin
        // hold the result side off while a whole 6 x 8 grid is offered
        drain_results();
        set_grid(11'd6, 11'd8);
        area  = 48;
        hold_req = 1'b1;
        repeat (48) send_cell(rand_cost());
        whole = 1'b1;
      end

      if (phase == 2) begin
        // widest rows: a width past the store acts as 1024, so the row wraps at 1024
        // and the second row reads back the full store
        drain_results();
        set_grid(11'd2047, 11'd2047);
        repeat (1026) send_cell(rand_cost());
        whole = 1'b0;
      end

      budget = cells_sent + RAND_CELLS / 3;
      while (cells_sent < budget) begin
        // after a finished grid, sometimes run on with the same size without a pause
        keep = whole && ($urandom_range(0, 3) == 0);
        if (!keep) begin
          drain_results();
          r = $urandom_range(1, 6);
          c = $urandom_range(1, 10);
          case ($urandom_range(0, 9))
            0:       r = $urandom_range(7, 30);
            1:       c = $urandom_range(11, 40);
            2:       r = 0;
            3:       c = 0;
            default: ;
          endcase
          set_grid(r[10:0], c[10:0]);
          area = (r == 0 ? 1 : r) * (c == 0 ? 1 : c);
        end
        // mostly whole grids, one or two back to back; the rest break off part way
        whole = ($urandom_range(0, 4) != 0);
        n = whole ? area * $urandom_range(1, 2) : $urandom_range(1, area);
        repeat (n) send_cell(rand_cost());
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d cell beats through %0d finished grids over %0d size settings,",
             cells_sent, grids_done, n_settings);
    $display("from zero and 1 x 1 up to a clamped 1024-wide grid.");
    if (mismatches == 0 && costs_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/gmcp_pkg.sv
sv/gmcp_cell.sv
sv/gmcp_pe.sv
sv/gmcp_skid.sv
sv/grid_min_cost_path.sv
tb/sv/path_cost_checker.sv
tb/sv/tb_top.sv
